// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies; the includer provides clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ising chain check failed");

// next-cycle implication, checked outside reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ising chain check failed");

`endif

// ===== sv/icsu_pkg.sv =====
// shared types, constants and helpers for the ising chain spin update block
// no dependencies
`default_nettype none

package icsu_pkg;

  localparam int MAX_SPINS    = 1024;
  localparam int SITE_W       = $clog2(MAX_SPINS);
  localparam int CNT_W        = $clog2(MAX_SPINS) + 1;
  localparam int SPIN_COUNT_W = 11;
  localparam int THR_W        = 17;
  localparam int THR_REG_W    = 3 * THR_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = THR_REG_W;
  localparam int SUM_W        = 12;
  localparam int CTR_W        = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH) + 1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_TRIAL   = 2'd1,
    ACT_MEASURE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_METRO  = 3'd0,
    REG_SPIN_COUNT = 3'd1,
    REG_METRO_UP   = 3'd2,
    REG_METRO_DOWN = 3'd3,
    REG_GIBBS      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TRIAL,
    OP_MEASURE,
    OP_CLEAR,
    OP_ERROR
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRIAL_NB,
    ST_TRIAL_EVAL,
    ST_MEASURE
  } back_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  site;
    logic [15:0] random_value;
    logic        spin_up;
  } in_word_t;

  typedef struct packed {
    logic                    status;
    logic                    spin_after;
    logic                    changed;
    logic signed [SUM_W-1:0] bond_sum;
    logic signed [SUM_W-1:0] magnetization;
    logic [CTR_W-1:0]        accepted_count;
    logic [CTR_W-1:0]        attempted_count;
  } out_word_t;

  typedef struct packed {
    logic                    use_metropolis;
    logic [SPIN_COUNT_W-1:0] spin_count;
    logic [THR_REG_W-1:0]    metro_up;
    logic [THR_REG_W-1:0]    metro_down;
    logic [THR_REG_W-1:0]    gibbs;
  } cfg_t;

  typedef struct packed {
    cmd_op_e           op;
    logic [SITE_W-1:0] site;
    logic [SITE_W-1:0] left;
    logic [SITE_W-1:0] right;
    logic [15:0]       rnd;
    logic              spin_up;
  } cmd_t;

  // effective ring length, saturated at the store depth
  function automatic logic [CNT_W-1:0] ring_len(input logic [SPIN_COUNT_W-1:0] sc);
    logic [CNT_W-1:0] n;
    if (32'(sc) > MAX_SPINS) begin
      n = CNT_W'(MAX_SPINS);
    end else begin
      n = CNT_W'(sc);
    end
    return n;
  endfunction

  // threshold field for neighbour index 0 (-2), 1 (0), 2 (+2)
  function automatic logic [THR_W-1:0] thr_pick(input logic [THR_REG_W-1:0] r,
                                                input logic [1:0] k);
    logic [THR_W-1:0] t;
    case (k)
      2'd0:    t = r[THR_W-1:0];
      2'd1:    t = r[2*THR_W-1:THR_W];
      default: t = r[3*THR_W-1:2*THR_W];
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ising_chain_spin_update.sv =====
// top level of the ising chain spin update block: config registers and wiring
// depends on icsu_pkg, icsu_front, icsu_queue, icsu_back (and icsu_ram below it)
//
//   channel   direction  handshake                 word
//   in        into block in_valid_i / in_stall_o   icsu_pkg::in_word_t
//   out       out        out_valid_o / out_stall_i icsu_pkg::out_word_t
//   cfg       into block cfg_we_i                  cfg_index_i, cfg_data_i
//
// load, clear and out-of-ring words finish in the idle state; a trial passes through
// idle, neighbour and eval states (two spin ram reads of the left/right neighbours,
// then the site, then write back); measure walks the ring, whose length is spin_count
// saturated at the store depth: the walk reads one spin per cycle from the ram
// a two-word queue lets the front take words while the back end is busy
// the result register holds a stalled word; the back end starts a word only when it is free
// async active-low reset clears control and counters and presets config, not the spin ram
`default_nettype none

module ising_chain_spin_update (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input words
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire icsu_pkg::in_word_t                 in_word_i,
  // result words
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output icsu_pkg::out_word_t                     out_word_o,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [icsu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [icsu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  icsu_pkg::cfg_t cfg_q, cfg_d;

  logic           push;
  logic           queue_full;
  icsu_pkg::cmd_t front_cmd;
  logic           q_valid;
  logic           q_pop;
  icsu_pkg::cmd_t q_cmd;

  // config registers, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        icsu_pkg::REG_USE_METRO:  cfg_d.use_metropolis = cfg_data_i[0];
        icsu_pkg::REG_SPIN_COUNT: cfg_d.spin_count = cfg_data_i[icsu_pkg::SPIN_COUNT_W-1:0];
        icsu_pkg::REG_METRO_UP:   cfg_d.metro_up   = cfg_data_i[icsu_pkg::THR_REG_W-1:0];
        icsu_pkg::REG_METRO_DOWN: cfg_d.metro_down = cfg_data_i[icsu_pkg::THR_REG_W-1:0];
        icsu_pkg::REG_GIBBS:      cfg_d.gibbs      = cfg_data_i[icsu_pkg::THR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_metropolis <= 1'b1;
      cfg_q.spin_count     <= icsu_pkg::SPIN_COUNT_W'(icsu_pkg::MAX_SPINS);
      cfg_q.metro_up       <= '0;
      cfg_q.metro_down     <= '0;
      cfg_q.gibbs          <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: site check and neighbour addresses
  icsu_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .ring_len_i   (icsu_pkg::ring_len(cfg_q.spin_count)),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  // decoupling queue
  icsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // back: spin store, trials, ring walk and result register
  icsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== sv/icsu_ram.sv =====
// generic single-write, dual-read ram with registered read data
// no dependencies
`default_nettype none

module icsu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sv/icsu_front.sv =====
// front end: takes input words, checks the site and works out the neighbours
// depends on icsu_pkg
`default_nettype none

module icsu_front (
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire icsu_pkg::in_word_t        in_word_i,
  input  wire logic [icsu_pkg::CNT_W-1:0] ring_len_i,
  input  wire logic                      queue_full_i,
  output logic                           push_o,
  output icsu_pkg::cmd_t                 cmd_o
);

  logic [icsu_pkg::CNT_W-1:0] site_ext;
  logic [icsu_pkg::CNT_W-1:0] n_m1;
  logic [icsu_pkg::CNT_W-1:0] site_p1;
  logic                       out_of_ring;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  assign site_ext    = icsu_pkg::CNT_W'(in_word_i.site);
  assign n_m1        = ring_len_i - icsu_pkg::CNT_W'(1);
  assign site_p1     = site_ext + icsu_pkg::CNT_W'(1);
  assign out_of_ring = (site_ext >= ring_len_i);

  always_comb begin
    cmd_o.site    = icsu_pkg::SITE_W'(in_word_i.site);
    cmd_o.rnd     = in_word_i.random_value;
    cmd_o.spin_up = in_word_i.spin_up;
    // periodic neighbours
    if (site_ext == '0) begin
      cmd_o.left = n_m1[icsu_pkg::SITE_W-1:0];
    end else begin
      cmd_o.left = icsu_pkg::SITE_W'(site_ext - icsu_pkg::CNT_W'(1));
    end
    if (site_p1 == ring_len_i) begin
      cmd_o.right = '0;
    end else begin
      cmd_o.right = site_p1[icsu_pkg::SITE_W-1:0];
    end
    case (in_word_i.action)
      icsu_pkg::ACT_LOAD: begin
        cmd_o.op = out_of_ring ? icsu_pkg::OP_ERROR : icsu_pkg::OP_LOAD;
      end
      icsu_pkg::ACT_TRIAL: begin
        cmd_o.op = out_of_ring ? icsu_pkg::OP_ERROR : icsu_pkg::OP_TRIAL;
      end
      icsu_pkg::ACT_MEASURE: cmd_o.op = icsu_pkg::OP_MEASURE;
      default:               cmd_o.op = icsu_pkg::OP_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/icsu_queue.sv =====
// short command queue between the front end and the execution back end
// depends on icsu_pkg
`default_nettype none

module icsu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire icsu_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output icsu_pkg::cmd_t      cmd_o
);

  icsu_pkg::cmd_t                   entry_q [icsu_pkg::QUEUE_DEPTH];
  logic [icsu_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [icsu_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [icsu_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == icsu_pkg::QCNT_W'(icsu_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + icsu_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + icsu_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + icsu_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - icsu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/icsu_back.sv =====
// back end: spin store, trial evaluation, ring walk, counters and result register
// depends on icsu_pkg and icsu_ram
`default_nettype none

module icsu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire icsu_pkg::cfg_t cfg_i,
  input  wire logic           q_valid_i,
  input  wire icsu_pkg::cmd_t q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output icsu_pkg::out_word_t out_word_o
);

  icsu_pkg::back_state_e state_q, state_d;

  icsu_pkg::cmd_t                     cmd_q, cmd_d;
  logic [1:0]                         nbsum_q, nbsum_d;
  logic [icsu_pkg::SITE_W-1:0]        idx_q, idx_d;
  logic                               first_q, first_d;
  logic                               prev_q, prev_d;
  logic signed [icsu_pkg::SUM_W-1:0]  bond_q, bond_d;
  logic signed [icsu_pkg::SUM_W-1:0]  mag_q, mag_d;
  logic [icsu_pkg::CTR_W-1:0]         acc_q, acc_d;
  logic [icsu_pkg::CTR_W-1:0]         att_q, att_d;
  logic                               out_valid_q, out_valid_d;
  icsu_pkg::out_word_t                out_q, out_d;

  logic                        ram_we;
  logic [icsu_pkg::SITE_W-1:0] ram_waddr;
  logic                        ram_wdata;
  logic [icsu_pkg::SITE_W-1:0] raddr_a;
  logic [icsu_pkg::SITE_W-1:0] raddr_b;
  logic                        rdata_a;
  logic                        rdata_b;

  logic [icsu_pkg::CNT_W-1:0]        n;
  logic [icsu_pkg::CNT_W-1:0]        n_m1;
  logic                              slot_free;
  logic                              start;
  logic                              walk_last;
  logic [icsu_pkg::THR_W-1:0]        thr;
  logic                              hit;
  logic                              spin_new;
  logic signed [icsu_pkg::SUM_W-1:0] step;
  logic signed [icsu_pkg::SUM_W-1:0] bond_n;
  logic signed [icsu_pkg::SUM_W-1:0] mag_n;
  logic                              first_s;

  assign n         = icsu_pkg::ring_len(cfg_i.spin_count);
  assign n_m1      = n - icsu_pkg::CNT_W'(1);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign start     = (state_q == icsu_pkg::ST_IDLE) && q_valid_i && slot_free;
  assign q_pop_o   = start;
  assign walk_last = (icsu_pkg::CNT_W'(idx_q) == n_m1);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  icsu_ram #(
    .WIDTH (1),
    .DEPTH (icsu_pkg::MAX_SPINS)
  ) u_spin_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // trial decision, rdata_a holds the current spin in the eval state
  always_comb begin
    if (cfg_i.use_metropolis) begin
      thr = icsu_pkg::thr_pick(rdata_a ? cfg_i.metro_up : cfg_i.metro_down, nbsum_q);
    end else begin
      thr = icsu_pkg::thr_pick(cfg_i.gibbs, nbsum_q);
    end
    hit = ({1'b0, cmd_q.rnd} <= thr);
    if (cfg_i.use_metropolis) begin
      spin_new = hit ? !rdata_a : rdata_a;
    end else begin
      spin_new = hit;
    end
  end

  // ring walk accumulation, rdata_a holds spin idx_q
  always_comb begin
    step    = rdata_a ? icsu_pkg::SUM_W'(1) : -icsu_pkg::SUM_W'(1);
    first_s = (idx_q == '0) ? rdata_a : first_q;
    if (idx_q == '0) begin
      mag_n  = step;
      bond_n = '0;
    end else begin
      mag_n  = mag_q + step;
      bond_n = bond_q + ((prev_q == rdata_a) ? icsu_pkg::SUM_W'(1) : -icsu_pkg::SUM_W'(1));
    end
    // closing bond back to site zero
    if (walk_last) begin
      bond_n = bond_n + ((first_s == rdata_a) ? icsu_pkg::SUM_W'(1) : -icsu_pkg::SUM_W'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      icsu_pkg::ST_IDLE: begin
        if (start && q_cmd_i.op == icsu_pkg::OP_TRIAL) begin
          state_d = icsu_pkg::ST_TRIAL_NB;
        end else if (start && q_cmd_i.op == icsu_pkg::OP_MEASURE && n != '0) begin
          state_d = icsu_pkg::ST_MEASURE;
        end
      end
      icsu_pkg::ST_TRIAL_NB:   state_d = icsu_pkg::ST_TRIAL_EVAL;
      icsu_pkg::ST_TRIAL_EVAL: state_d = icsu_pkg::ST_IDLE;
      icsu_pkg::ST_MEASURE: begin
        if (walk_last) begin
          state_d = icsu_pkg::ST_IDLE;
        end
      end
      default: state_d = icsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    nbsum_d     = nbsum_q;
    idx_d       = idx_q;
    first_d     = first_q;
    prev_d      = prev_q;
    bond_d      = bond_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    att_d       = att_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cmd_q.site;
    ram_wdata   = spin_new;
    raddr_a     = q_cmd_i.left;
    raddr_b     = q_cmd_i.right;

    case (state_q)
      icsu_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d = q_cmd_i;
          out_d = '0;
          case (q_cmd_i.op)
            icsu_pkg::OP_LOAD: begin
              ram_we           = 1'b1;
              ram_waddr        = q_cmd_i.site;
              ram_wdata        = q_cmd_i.spin_up;
              out_d.spin_after = q_cmd_i.spin_up;
              out_valid_d      = 1'b1;
            end
            icsu_pkg::OP_ERROR: begin
              out_d.status = 1'b1;
              out_valid_d  = 1'b1;
            end
            icsu_pkg::OP_CLEAR: begin
              acc_d       = '0;
              att_d       = '0;
              out_valid_d = 1'b1;
            end
            icsu_pkg::OP_MEASURE: begin
              raddr_a = '0;
              idx_d   = '0;
              // empty ring answers at once
              if (n == '0) begin
                out_valid_d = 1'b1;
              end
            end
            default: ;
          endcase
          out_d.accepted_count  = acc_d;
          out_d.attempted_count = att_d;
        end
      end
      icsu_pkg::ST_TRIAL_NB: begin
        nbsum_d = {1'b0, rdata_a} + {1'b0, rdata_b};
        raddr_a = cmd_q.site;
      end
      icsu_pkg::ST_TRIAL_EVAL: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_q.site;
        ram_wdata = spin_new;
        att_d     = att_q + icsu_pkg::CTR_W'(1);
        if (hit || !cfg_i.use_metropolis) begin
          acc_d = acc_q + icsu_pkg::CTR_W'(1);
        end
        out_d                 = '0;
        out_d.spin_after      = spin_new;
        out_d.changed         = hit || !cfg_i.use_metropolis;
        out_d.accepted_count  = acc_d;
        out_d.attempted_count = att_d;
        out_valid_d           = 1'b1;
      end
      icsu_pkg::ST_MEASURE: begin
        raddr_a = idx_q + icsu_pkg::SITE_W'(1);
        idx_d   = idx_q + icsu_pkg::SITE_W'(1);
        first_d = first_s;
        prev_d  = rdata_a;
        bond_d  = bond_n;
        mag_d   = mag_n;
        if (walk_last) begin
          out_d                 = '0;
          out_d.bond_sum        = bond_n;
          out_d.magnetization   = mag_n;
          out_d.accepted_count  = acc_q;
          out_d.attempted_count = att_q;
          out_valid_d           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= icsu_pkg::ST_IDLE;
      acc_q       <= '0;
      att_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      att_q       <= att_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    nbsum_q <= nbsum_d;
    idx_q   <= idx_d;
    first_q <= first_d;
    prev_q  <= prev_d;
    bond_q  <= bond_d;
    mag_q   <= mag_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/icsu_checker.sv =====
// port-level checks for the ising chain spin update block, bound to the top level
// depends on icsu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module icsu_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire icsu_pkg::out_word_t out_word_i
);

  // a stalled result word stays put
  `CHK_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_word_i))

  // an out-of-ring word reports nothing but the counters
  `CHK_IMPLY(a_err_clean, out_valid_i && out_word_i.status, !out_word_i.spin_after && !out_word_i.changed && out_word_i.bond_sum == 0 && out_word_i.magnetization == 0)

  // a changed spin never comes with ring sums or an error status
  `CHK_IMPLY(a_chg_no_sums, out_valid_i && out_word_i.changed, out_word_i.bond_sum == 0 && out_word_i.magnetization == 0 && !out_word_i.status)

endmodule

bind ising_chain_spin_update icsu_checker u_icsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);

`default_nettype wire
